// ===== sv/scd_pkg.sv =====
`timescale 1ns / 1ps
package scd_pkg;

	localparam int PIX_W      = 8;
	localparam int CNT_W      = 5;
	localparam int THR_W      = 8;
	localparam int DIM_REG_W  = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

	localparam logic [THR_W-1:0]     THR_RESET = 8'd20;
	localparam logic [DIM_REG_W-1:0] DIM_RESET = 10'd512;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_FETCH = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_LOAD,
		S_P1_POS,
		S_CEN,
		S_SCAN,
		S_DRAIN,
		S_P2,
		S_F_IDLE,
		S_F_DIV,
		S_F_OUT
	} state_t;

endpackage

// ===== sv/scd_div.sv =====
`timescale 1ns / 1ps
module scd_div #(
	parameter int NUM_W = 18,
	parameter int DEN_W = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic [STEP_W-1:0] step_q;
	logic              run_q;
	logic              done_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W:0]    trial;
	logic              fit;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fit   = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else if (start) begin
			quo_q  <= num;
			rem_q  <= '0;
			den_q  <= den;
			step_q <= STEP_W'(NUM_W);
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			quo_q  <= {quo_q[NUM_W-2:0], fit};
			rem_q  <= fit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ===== sv/susan_corner_detect_top.sv =====
`timescale 1ns / 1ps
// pixels are loaded into the pixel memory; after the last pixel the frame is computed in two passes
// over the pixel and response memories, with no input accepted
// each fetch is served by the serial position divider and the single read port scanning the
// disc, one neighbour per cycle
// reset: after arst_n rises the response memory is cleared before the first pixel is accepted;
// configuration writes are taken throughout
module susan_corner_detect_top #(
	parameter int MAX_WIDTH   = 512,
	parameter int MAX_HEIGHT  = 512,
	parameter int DISC_RADIUS = 3
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // pixel_value[7:0]
	input  logic                             s_tuser,   // kind
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,   // corner_flag, corner_response[5:1], zero
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [scd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [scd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int TW    = WW + HW;
	localparam int IW    = AW + 2;
	localparam int OW    = $clog2(DISC_RADIUS + 1) + 1;
	localparam int QW    = 2 * OW + 1;
	localparam int CWW   = (WW > scd_pkg::DIM_REG_W) ? WW : scd_pkg::DIM_REG_W;
	localparam int CWH   = (HW > scd_pkg::DIM_REG_W) ? HW : scd_pkg::DIM_REG_W;
	localparam int CN    = scd_pkg::CNT_W;
	localparam int PW    = scd_pkg::PIX_W;
	localparam int BW    = 2 * scd_pkg::CNT_W;

	localparam logic signed [OW-1:0] RPOS = OW'(DISC_RADIUS);
	localparam logic signed [OW-1:0] RNEG = -RPOS;

	scd_pkg::state_t state_q, state_d;

	logic [scd_pkg::THR_W-1:0]     thr_q, lthr_q;
	logic [scd_pkg::DIM_REG_W-1:0] width_q, height_q;
	logic [WW-1:0] eff_w, lw_q, px_q;
	logic [HW-1:0] eff_h, lh_q, py_q;
	logic [CWW-1:0] wreg_ext;
	logic [CWH-1:0] hreg_ext;
	logic [TW-1:0]  total;
	logic [AW-1:0]  load_pos_q, fetch_pos_q, idx_q, cen_addr_q, clr_q, p2addr_s1;
	logic signed [OW-1:0] dx_q, dy_q;
	logic signed [QW-1:0] dxe, dye, dsq;
	logic disc_ok, scan_end;
	logic scan_en_q, fetch_mode_q, cen_s1, nbr_s1, good_q, last_q;
	logic p2_done_q, p2v_s1, p2int_s1;
	logic [PW-1:0] centre_q;
	logic [CN-1:0] cnt_q, largest_q, cnt_fin, cnt_rd, g_w, resp2;
	logic [CN+1:0] g3;
	logic good_fin, hit, load_last, fetch_last, cur_last, s_acc;
	logic [PW-1:0] absd;
	logic signed [AW+1:0] nbr_sum;
	logic [AW-1:0] rd_addr, b_waddr;
	logic pix_we, b_we, div_start, div_done;
	logic [BW-1:0] b_wdata;
	logic [PW-1:0] pix_rd;
	logic [BW-1:0] b_rd;
	logic [AW-1:0] div_quo;
	logic [WW-1:0] div_rem;
	logic [IW-1:0] chk_x, chk_y;
	logic interior, in_frame;
	logic m_tvalid_q, m_flag_q, m_last_q;
	logic [CN-1:0] m_resp_q;

	logic [PW-1:0] pix_mem [DEPTH];
	logic [BW-1:0] b_mem   [DEPTH];

	// frame geometry from the registers, clamped to 1 .. max
	assign wreg_ext = CWW'(width_q);
	assign hreg_ext = CWH'(height_q);
	assign eff_w = (width_q == '0) ? WW'(1) :
		(wreg_ext > CWW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(wreg_ext);
	assign eff_h = (height_q == '0) ? HW'(1) :
		(hreg_ext > CWH'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(hreg_ext);
	assign total = TW'(eff_w) * TW'(eff_h);

	assign load_last  = (TW'(load_pos_q) + TW'(1)) >= total;
	assign fetch_last = (TW'(fetch_pos_q) + TW'(1)) >= total;
	assign cur_last   = (px_q == lw_q - WW'(1)) && (py_q == lh_q - HW'(1));

	assign s_tready = (state_q == scd_pkg::S_LOAD) || (state_q == scd_pkg::S_F_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// interior test, on the pass cursor or on the divided fetch position
	assign chk_x = (state_q == scd_pkg::S_F_DIV) ? IW'(div_rem) : IW'(px_q);
	assign chk_y = (state_q == scd_pkg::S_F_DIV) ? IW'(div_quo) : IW'(py_q);
	assign interior = (chk_x >= IW'(DISC_RADIUS)) && (chk_y >= IW'(DISC_RADIUS)) &&
		(chk_x + IW'(DISC_RADIUS) < IW'(lw_q)) && (chk_y + IW'(DISC_RADIUS) < IW'(lh_q));
	assign in_frame = chk_y < IW'(lh_q);

	// disc offsets walk the (2R+1)^2 square, off-disc points and the centre are skipped
	assign dxe = QW'(dx_q);
	assign dye = QW'(dy_q);
	assign dsq = dxe * dxe + dye * dye;
	assign disc_ok = (dsq <= QW'(DISC_RADIUS * DISC_RADIUS)) && !(dx_q == '0 && dy_q == '0);
	assign scan_end = (dx_q == RPOS) && (dy_q == RPOS);

	assign nbr_sum = $signed({2'b00, cen_addr_q}) +
		$signed((AW + 2)'(dy_q)) * $signed((AW + 2)'({1'b0, lw_q})) +
		$signed((AW + 2)'(dx_q));

	assign absd = (centre_q >= pix_rd) ? centre_q - pix_rd : pix_rd - centre_q;
	assign hit  = absd <= lthr_q;
	assign cnt_fin = (nbr_s1 && !fetch_mode_q && hit && cnt_q != '1) ? cnt_q + CN'(1) : cnt_q;
	assign good_fin = good_q &&
		!(nbr_s1 && fetch_mode_q && !(centre_q[CN-1:0] > b_rd[CN-1:0]));

	// geometric threshold 3*max/4
	assign g3    = {2'b00, largest_q} + {1'b0, largest_q, 1'b0};
	assign g_w   = g3[CN+1:2];
	assign cnt_rd = b_rd[BW-1:CN];
	assign resp2 = (p2int_s1 && cnt_rd < g_w) ? g_w - cnt_rd : '0;

	scd_div #(
		.NUM_W(AW),
		.DEN_W(WW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (fetch_pos_q),
		.den   (eff_w),
		.done  (div_done),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	always_ff @(posedge clk) begin
		if (pix_we) begin
			pix_mem[load_pos_q] <= s_tdata;
		end
		pix_rd <= pix_mem[rd_addr];
	end

	// count in the upper half, response in the lower half
	always_ff @(posedge clk) begin
		if (b_we) begin
			b_mem[b_waddr] <= b_wdata;
		end
		b_rd <= b_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scd_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		rd_addr   = cen_addr_q;
		pix_we    = 1'b0;
		b_we      = 1'b0;
		b_waddr   = cen_addr_q;
		b_wdata   = '0;
		div_start = 1'b0;
		case (state_q)
			scd_pkg::S_CLEAR: begin
				b_we    = 1'b1;
				b_waddr = clr_q;
				if (clr_q == AW'(DEPTH - 1)) state_d = scd_pkg::S_LOAD;
			end
			scd_pkg::S_LOAD: begin
				if (s_acc && s_tuser == scd_pkg::KIND_LOAD) begin
					pix_we = 1'b1;
					if (load_last) state_d = scd_pkg::S_P1_POS;
				end
			end
			scd_pkg::S_P1_POS: begin
				if (interior) state_d = scd_pkg::S_CEN;
				else if (cur_last) state_d = scd_pkg::S_P2;
			end
			scd_pkg::S_CEN: begin
				state_d = scd_pkg::S_SCAN;
			end
			scd_pkg::S_SCAN: begin
				rd_addr = nbr_sum[AW-1:0];
				if (!scan_en_q || scan_end) state_d = scd_pkg::S_DRAIN;
			end
			scd_pkg::S_DRAIN: begin
				if (fetch_mode_q) begin
					state_d = scd_pkg::S_F_OUT;
				end else begin
					b_we    = 1'b1;
					b_wdata = {cnt_fin, {CN{1'b0}}};
					state_d = cur_last ? scd_pkg::S_P2 : scd_pkg::S_P1_POS;
				end
			end
			scd_pkg::S_P2: begin
				rd_addr = idx_q;
				if (p2v_s1) begin
					b_we    = 1'b1;
					b_waddr = p2addr_s1;
					b_wdata = {cnt_rd, resp2};
				end
				if (p2_done_q && !p2v_s1) state_d = scd_pkg::S_F_IDLE;
			end
			scd_pkg::S_F_IDLE: begin
				if (s_acc && s_tuser == scd_pkg::KIND_FETCH) begin
					div_start = 1'b1;
					state_d   = scd_pkg::S_F_DIV;
				end
			end
			scd_pkg::S_F_DIV: begin
				if (div_done) state_d = scd_pkg::S_CEN;
			end
			scd_pkg::S_F_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = last_q ? scd_pkg::S_LOAD : scd_pkg::S_F_IDLE;
				end
			end
			default: begin
				state_d = scd_pkg::S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q        <= scd_pkg::THR_RESET;
			width_q      <= scd_pkg::DIM_RESET;
			height_q     <= scd_pkg::DIM_RESET;
			lthr_q       <= '0;
			lw_q         <= WW'(1);
			lh_q         <= HW'(1);
			load_pos_q   <= '0;
			fetch_pos_q  <= '0;
			idx_q        <= '0;
			px_q         <= '0;
			py_q         <= '0;
			cen_addr_q   <= '0;
			clr_q        <= '0;
			dx_q         <= '0;
			dy_q         <= '0;
			scan_en_q    <= 1'b0;
			fetch_mode_q <= 1'b0;
			cen_s1       <= 1'b0;
			nbr_s1       <= 1'b0;
			centre_q     <= '0;
			cnt_q        <= '0;
			good_q       <= 1'b0;
			largest_q    <= '0;
			last_q       <= 1'b0;
			p2_done_q    <= 1'b0;
			p2v_s1       <= 1'b0;
			p2int_s1     <= 1'b0;
			p2addr_s1    <= '0;
			m_tvalid_q   <= 1'b0;
			m_flag_q     <= 1'b0;
			m_resp_q     <= '0;
			m_last_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					scd_pkg::REG_THRESHOLD: thr_q    <= cfg_data[scd_pkg::THR_W-1:0];
					scd_pkg::REG_WIDTH:     width_q  <= cfg_data;
					scd_pkg::REG_HEIGHT:    height_q <= cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid_q && m_tready && state_q != scd_pkg::S_F_OUT) m_tvalid_q <= 1'b0;

			// read data returns in the cycle after the address
			cen_s1 <= (state_q == scd_pkg::S_CEN);
			nbr_s1 <= (state_q == scd_pkg::S_SCAN) && scan_en_q && disc_ok;
			if (cen_s1) centre_q <= fetch_mode_q ? PW'(b_rd[CN-1:0]) : pix_rd;
			if (nbr_s1) begin
				cnt_q  <= cnt_fin;
				good_q <= good_fin;
			end

			case (state_q)
				scd_pkg::S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
				end
				scd_pkg::S_LOAD: begin
					if (s_acc && s_tuser == scd_pkg::KIND_LOAD) begin
						if (load_last) begin
							lw_q         <= eff_w;
							lh_q         <= eff_h;
							lthr_q       <= thr_q;
							px_q         <= '0;
							py_q         <= '0;
							idx_q        <= '0;
							largest_q    <= '0;
							load_pos_q   <= '0;
							fetch_mode_q <= 1'b0;
						end else begin
							load_pos_q <= load_pos_q + AW'(1);
						end
					end
				end
				scd_pkg::S_P1_POS: begin
					if (interior) begin
						cen_addr_q <= idx_q;
						scan_en_q  <= 1'b1;
					end else if (cur_last) begin
						px_q      <= '0;
						py_q      <= '0;
						idx_q     <= '0;
						p2_done_q <= 1'b0;
						p2v_s1    <= 1'b0;
					end else begin
						idx_q <= idx_q + AW'(1);
						if (px_q == lw_q - WW'(1)) begin
							px_q <= '0;
							py_q <= py_q + HW'(1);
						end else begin
							px_q <= px_q + WW'(1);
						end
					end
				end
				scd_pkg::S_CEN: begin
					dx_q   <= RNEG;
					dy_q   <= RNEG;
					cnt_q  <= '0;
					good_q <= 1'b1;
				end
				scd_pkg::S_SCAN: begin
					if (dx_q == RPOS) begin
						dx_q <= RNEG;
						dy_q <= dy_q + OW'(1);
					end else begin
						dx_q <= dx_q + OW'(1);
					end
				end
				scd_pkg::S_DRAIN: begin
					if (!fetch_mode_q) begin
						if (cnt_fin > largest_q) largest_q <= cnt_fin;
						if (cur_last) begin
							px_q      <= '0;
							py_q      <= '0;
							idx_q     <= '0;
							p2_done_q <= 1'b0;
							p2v_s1    <= 1'b0;
						end else begin
							idx_q <= idx_q + AW'(1);
							if (px_q == lw_q - WW'(1)) begin
								px_q <= '0;
								py_q <= py_q + HW'(1);
							end else begin
								px_q <= px_q + WW'(1);
							end
						end
					end
				end
				scd_pkg::S_P2: begin
					if (!p2_done_q) begin
						p2v_s1    <= 1'b1;
						p2addr_s1 <= idx_q;
						p2int_s1  <= interior;
						idx_q     <= idx_q + AW'(1);
						if (cur_last) p2_done_q <= 1'b1;
						if (px_q == lw_q - WW'(1)) begin
							px_q <= '0;
							py_q <= py_q + HW'(1);
						end else begin
							px_q <= px_q + WW'(1);
						end
					end else begin
						p2v_s1      <= 1'b0;
						fetch_pos_q <= '0;
					end
				end
				scd_pkg::S_F_IDLE: begin
					if (s_acc && s_tuser == scd_pkg::KIND_FETCH) begin
						lw_q         <= eff_w;
						lh_q         <= eff_h;
						last_q       <= fetch_last;
						cen_addr_q   <= fetch_pos_q;
						fetch_mode_q <= 1'b1;
					end
				end
				scd_pkg::S_F_DIV: begin
					if (div_done) scan_en_q <= interior && in_frame;
				end
				scd_pkg::S_F_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_flag_q   <= scan_en_q && (centre_q != '0) && good_fin;
						m_resp_q   <= centre_q[CN-1:0];
						m_last_q   <= last_q;
						if (last_q) begin
							fetch_pos_q <= '0;
							load_pos_q  <= '0;
						end else begin
							fetch_pos_q <= fetch_pos_q + AW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, m_resp_q, m_flag_q};
	assign m_tlast  = m_last_q;

	a_clear_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == scd_pkg::S_CLEAR) |-> !s_tready)
		else $error("input accepted during memory clear");

	a_nbr_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		nbr_s1 |-> (state_q == scd_pkg::S_SCAN || state_q == scd_pkg::S_DRAIN))
		else $error("neighbour read data outside disc scan");

	a_bmem_write: assert property (@(posedge clk) disable iff (!arst_n)
		b_we |-> (state_q == scd_pkg::S_CLEAR || state_q == scd_pkg::S_DRAIN ||
			state_q == scd_pkg::S_P2))
		else $error("response memory written outside clear or compute");

	a_corner_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tdata[5:1] != 5'd0))
		else $error("corner flagged with zero response");

endmodule

// ===== bench/tb_susan_corner_detect_top.sv =====
`timescale 1ns / 1ps
module tb_susan_corner_detect_top;

	localparam int MAXW = 512;
	localparam int MAXH = 512;
	localparam int RAD = 3;
	localparam int STALL_LIMIT = 1200000;

	typedef struct {
		bit       flag;
		bit [4:0] response;
		bit       last;
	} corner_result_t;

	class corner_scoreboard;
		bit [7:0] pix [0:MAXW*MAXH-1];
		bit [4:0] resp [0:MAXW*MAXH-1];
		int thr = 20;
		int w = 512;
		int h = 512;
		bit fetching;
		int load_pos;
		int fetch_pos;
		int errors;
		corner_result_t pending [$];

		function void set_reg(logic [scd_pkg::CFG_IDX_W-1:0] idx, int val);
			if (idx == scd_pkg::REG_THRESHOLD) thr = val & 8'hff;
			else if (idx == scd_pkg::REG_WIDTH) w = (val < 1) ? 1 : (val > MAXW) ? MAXW : val;
			else if (idx == scd_pkg::REG_HEIGHT) h = (val < 1) ? 1 : (val > MAXH) ? MAXH : val;
		endfunction

		function bit interior(int x, int y);
			return x >= RAD && y >= RAD && x + RAD < w && y + RAD < h;
		endfunction

		function bit disc(int dx, int dy);
			return dx*dx + dy*dy <= RAD*RAD && (dx != 0 || dy != 0);
		endfunction

		// usan counts, then g = 3*max/4 and the responses
		function void build_responses();
			int cnt [];
			int top;
			int g;
			int c;
			int d;
			cnt = new[w*h];
			top = 0;
			for (int y = 0; y < h; y++)
				for (int x = 0; x < w; x++) begin
					c = 0;
					if (interior(x, y)) begin
						for (int dy = -RAD; dy <= RAD; dy++)
							for (int dx = -RAD; dx <= RAD; dx++)
								if (disc(dx, dy)) begin
									d = int'(pix[y*w+x]) - int'(pix[(y+dy)*w+x+dx]);
									if (d < 0) d = -d;
									if (d <= thr && c < 31) c++;
								end
						if (c > top) top = c;
					end
					cnt[y*w+x] = c;
				end
			g = 3 * top / 4;
			for (int y = 0; y < h; y++)
				for (int x = 0; x < w; x++)
					resp[y*w+x] = (interior(x, y) && cnt[y*w+x] < g) ? 5'(g - cnt[y*w+x]) : 5'd0;
		endfunction

		function bit is_corner(int pos);
			int x;
			int y;
			x = pos % w;
			y = pos / w;
			if (y >= h || !interior(x, y) || resp[pos] == 0) return 0;
			for (int dy = -RAD; dy <= RAD; dy++)
				for (int dx = -RAD; dx <= RAD; dx++)
					if (disc(dx, dy) && !(resp[pos] > resp[pos + dy*w + dx])) return 0;
			return 1;
		endfunction

		function void note_item(logic kind, bit [7:0] p);
			corner_result_t r;
			if (kind == scd_pkg::KIND_LOAD) begin
				if (fetching) return;
				pix[load_pos] = p;
				if (load_pos + 1 >= w*h) begin
					build_responses();
					load_pos = 0;
					fetch_pos = 0;
					fetching = 1;
				end else
					load_pos++;
				return;
			end
			if (!fetching) return;
			r.flag = is_corner(fetch_pos);
			r.response = resp[fetch_pos];
			r.last = fetch_pos + 1 >= w*h;
			pending.push_back(r);
			if (r.last) begin
				fetching = 0;
				fetch_pos = 0;
				load_pos = 0;
			end else
				fetch_pos++;
		endfunction

		function void check_result(bit [7:0] data, bit last);
			corner_result_t r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result data=%h last=%b", $realtime, data, last);
				errors++;
				return;
			end
			r = pending.pop_front();
			if (data[0] != r.flag) begin
				$display("%0t: corner_flag expected %b actual %b", $realtime, r.flag, data[0]);
				errors++;
			end
			if (data[5:1] != r.response) begin
				$display("%0t: corner_response expected %0d actual %0d", $realtime,
					r.response, data[5:1]);
				errors++;
			end
			if (data[7:6] != 2'b00) begin
				$display("%0t: pad bits expected 0 actual %b", $realtime, data[7:6]);
				errors++;
			end
			if (last != r.last) begin
				$display("%0t: last_of_frame expected %b actual %b", $realtime, r.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [7:0]                     s_tdata;
	logic                           s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [7:0]                     m_tdata;
	logic                           m_tlast;
	logic                           cfg_we;
	logic [scd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [scd_pkg::CFG_DATA_W-1:0] cfg_data;

	corner_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles;

	susan_corner_detect_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// only called with the block idle between frames
	task automatic set_frame(int thr, int w, int h);
		int vals [3];
		logic [scd_pkg::CFG_IDX_W-1:0] idx [3];
		vals = '{thr, w, h};
		idx = '{scd_pkg::REG_THRESHOLD, scd_pkg::REG_WIDTH, scd_pkg::REG_HEIGHT};
		for (int i = 0; i < 3; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= scd_pkg::CFG_DATA_W'(vals[i]);
			sb.set_reg(idx[i], vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_item(logic kind, bit [7:0] p);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= p;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_item(kind, p);
	endtask

	// mode 0 random, 1 rectangle on a flat background, 2 black and white
	task automatic run_frame(int thr, int w, int h, int mode, int noise_pct);
		int bg;
		int fg;
		int x0;
		int x1;
		int y0;
		int y1;
		bit [7:0] p;
		set_frame(thr, w, h);
		bg = $urandom_range(255);
		fg = $urandom_range(255);
		x0 = $urandom_range(w-1);
		x1 = $urandom_range(x0, w-1);
		y0 = $urandom_range(h-1);
		y1 = $urandom_range(y0, h-1);
		for (int i = 0; i < w*h; i++) begin
			case (mode)
				0: p = 8'($urandom_range(255));
				1: begin
					p = (i%w >= x0 && i%w <= x1 && i/w >= y0 && i/w <= y1) ? 8'(fg) : 8'(bg);
					if ($urandom_range(9) == 0) p = p ^ 8'($urandom_range(3));
				end
				default: p = $urandom_range(1) ? 8'hff : 8'h00;
			endcase
			// stray fetch while loading is dropped by the block
			if ($urandom_range(99) < noise_pct)
				send_item(scd_pkg::KIND_FETCH, 8'($urandom_range(255)));
			send_item(scd_pkg::KIND_LOAD, p);
		end
		for (int i = 0; i < w*h; i++) begin
			if ($urandom_range(99) < noise_pct)
				send_item(scd_pkg::KIND_LOAD, 8'($urandom_range(255)));
			send_item(scd_pkg::KIND_FETCH, 8'($urandom_range(255)));
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = scd_pkg::KIND_LOAD;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 7;
		recv_idle_pct = 64;
		quiet_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest frame, exact threshold, pure black and white, stray items on both sides
		run_frame(0, 7, 7, 2, 20);
		for (int f = 0; f < 9; f++) begin
			int thr;
			if (f == 3) begin
				send_idle_pct = 64;
				recv_idle_pct = 7;
			end
			if (f == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case ($urandom_range(3))
				0: thr = 0;
				1: thr = 255;
				2: thr = 20;
				default: thr = $urandom_range(255);
			endcase
			run_frame(thr, $urandom_range(7, 9), $urandom_range(7, 9), f % 3, 5);
		end
		// long row in a minimal-height frame
		run_frame(30, 22, 7, 1, 2);

		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
